### rtl/nearest_timestamp_lookup_assert.svh
// Assertion macros for the nearest timestamp lookup checker.
// Used by nts_chk.sv; no other dependencies.
`ifndef NEAREST_TIMESTAMP_LOOKUP_ASSERT_SVH
`define NEAREST_TIMESTAMP_LOOKUP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nearest_timestamp_lookup: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define NTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nearest_timestamp_lookup: assertion failed");

`endif

### rtl/nts_pkg.sv
// Shared types and codes for the nearest timestamp lookup block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package nts_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int TIME_W   = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_NEIGHBOR,
        S_DECIDE,
        S_PICK,
        S_OUTPUT
    } state_t;

endpackage

`default_nettype wire

### rtl/nearest_timestamp_lookup.sv
// Nearest timestamp lookup: a timestamp table in one synchronous memory
// with a lower-bound binary search controller. Depends on nts_pkg.
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------
// command   | in        | s_valid / s_ready  | s_cmd, s_time_ns
// result    | out       | m_valid / m_ready  | m_status, m_entry_index, m_entry_time_ns
//
// Clear, append and unused commands: the result goes to the working registers, then from S_OUTPUT
// to the output register; no new command is taken until idle. A query: one read per search step,
// at most floor(log2(entry count)) + 1 steps, then one or two neighbor reads before S_OUTPUT.
// Reset (aresetn, synchronous) empties the table; the memory itself is not cleared.
// A new transaction is taken while the previous result waits in the output register;
// a stalled result holds the block in its output state until the register frees up.

module nearest_timestamp_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [nts_pkg::CMD_W-1:0]           s_cmd,
    input  wire  signed [nts_pkg::TIME_W-1:0]   s_time_ns,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [nts_pkg::STATUS_W-1:0]        m_status,
    output logic [nts_pkg::INDEX_W-1:0]         m_entry_index,
    output logic signed [nts_pkg::TIME_W-1:0]   m_entry_time_ns
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TW    = nts_pkg::TIME_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Timestamp memory, one write and one registered read port.
    logic [TW-1:0] mem [TABLE_DEPTH];
    logic [TW-1:0] rd_data_reg;
    logic          rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic          wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [TW-1:0] wr_data;

    // Control and working registers.
    nts_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] pick_reg, pick_next;
    logic [TW-1:0]    query_reg, query_next;
    logic [TW-1:0]    before_reg, before_next;
    logic [nts_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [nts_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [TW-1:0]                res_time_reg, res_time_next;

    // Output register.
    logic                         m_valid_reg, m_valid_next;
    logic [nts_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [nts_pkg::INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [TW-1:0]                m_time_reg, m_time_next;

    // Search step helpers.
    logic             lt;
    logic [CNT_W-1:0] lo_step, hi_step, mid_step;

    // Map a table index onto the 10-bit result field.
    function automatic logic [nts_pkg::INDEX_W-1:0] to_index(input logic [CNT_W-1:0] v);
        logic [CNT_W+nts_pkg::INDEX_W-1:0] w;
        w = {{nts_pkg::INDEX_W{1'b0}}, v};
        return w[nts_pkg::INDEX_W-1:0];
    endfunction

    // True when the earlier neighbor is at least as close: 2q <= a + b, exactly.
    function automatic logic before_wins(input logic [TW-1:0] q, input logic [TW-1:0] b,
                                         input logic [TW-1:0] a);
        logic signed [TW+1:0] twice_q;
        logic signed [TW+1:0] sum_ab;
        twice_q = $signed({q[TW-1], q, 1'b0});
        sum_ab  = $signed({{2{a[TW-1]}}, a}) + $signed({{2{b[TW-1]}}, b});
        return twice_q <= sum_ab;
    endfunction

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Narrowing step of the lower-bound search on the entry just read.
    always_comb begin
        lt       = $signed(rd_data_reg) < $signed(query_reg);
        lo_step  = lt ? (mid_reg + CNT_W'(1)) : lo_reg;
        hi_step  = lt ? hi_reg : mid_reg;
        mid_step = lo_step + ((hi_step - lo_step) >> 1);
    end

    // Next state, memory access and result selection.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pick_next       = pick_reg;
        query_next      = query_reg;
        before_next     = before_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_time_next   = res_time_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_time_next     = m_time_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = s_time_ns;
        s_ready         = 1'b0;

        case (state_reg)
            nts_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_status_next = nts_pkg::STATUS_OK;
                    res_index_next  = '0;
                    res_time_next   = '0;
                    state_next      = nts_pkg::S_OUTPUT;
                    case (s_cmd)
                        nts_pkg::CMD_CLEAR: begin
                            count_next = '0;
                        end
                        nts_pkg::CMD_APPEND: begin
                            if (count_reg == DEPTH_CNT) begin
                                res_status_next = nts_pkg::STATUS_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                res_index_next = to_index(count_reg);
                                res_time_next  = s_time_ns;
                            end
                        end
                        nts_pkg::CMD_QUERY: begin
                            if (count_reg == '0) begin
                                res_status_next = nts_pkg::STATUS_EMPTY;
                            end else begin
                                query_next = s_time_ns;
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = count_reg >> 1;
                                rd_en      = 1'b1;
                                rd_addr    = mid_next[IDX_W-1:0];
                                state_next = nts_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One search step per cycle; the next read goes out with the decision.
            nts_pkg::S_SEARCH: begin
                lo_next = lo_step;
                hi_next = hi_step;
                rd_en   = 1'b1;
                if (lo_step < hi_step) begin
                    mid_next = mid_step;
                    rd_addr  = mid_step[IDX_W-1:0];
                end else if (lo_step == '0) begin
                    pick_next  = '0;
                    rd_addr    = '0;
                    state_next = nts_pkg::S_PICK;
                end else if (lo_step == count_reg) begin
                    pick_next  = count_reg - CNT_W'(1);
                    rd_addr    = pick_next[IDX_W-1:0];
                    state_next = nts_pkg::S_PICK;
                end else begin
                    pick_next  = lo_step - CNT_W'(1);
                    rd_addr    = pick_next[IDX_W-1:0];
                    state_next = nts_pkg::S_NEIGHBOR;
                end
            end

            // Earlier neighbor is in; fetch the later one.
            nts_pkg::S_NEIGHBOR: begin
                before_next = rd_data_reg;
                rd_en       = 1'b1;
                rd_addr     = lo_reg[IDX_W-1:0];
                state_next  = nts_pkg::S_DECIDE;
            end

            // Pick the nearer neighbor; a tie goes to the earlier one.
            nts_pkg::S_DECIDE: begin
                res_status_next = nts_pkg::STATUS_OK;
                if (before_wins(query_reg, before_reg, rd_data_reg)) begin
                    res_index_next = to_index(pick_reg);
                    res_time_next  = before_reg;
                end else begin
                    res_index_next = to_index(lo_reg);
                    res_time_next  = rd_data_reg;
                end
                state_next = nts_pkg::S_OUTPUT;
            end

            // Query answered by the first or the last entry.
            nts_pkg::S_PICK: begin
                res_status_next = nts_pkg::STATUS_OK;
                res_index_next  = to_index(pick_reg);
                res_time_next   = rd_data_reg;
                state_next      = nts_pkg::S_OUTPUT;
            end

            // Hand the result to the output register once it is free.
            nts_pkg::S_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_time_next   = res_time_reg;
                    state_next    = nts_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = nts_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nts_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pick_reg       <= pick_next;
        query_reg      <= query_next;
        before_reg     <= before_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_time_reg   <= res_time_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_time_reg     <= m_time_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_entry_index   = m_index_reg;
    assign m_entry_time_ns = m_time_reg;

endmodule

`default_nettype wire

### rtl/nts_chk.sv
// Port-level checker for nearest_timestamp_lookup, bound to the top level.
// Depends on nts_pkg and nearest_timestamp_lookup_assert.svh.
`default_nettype none

`include "nearest_timestamp_lookup_assert.svh"

module nts_chk (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire [nts_pkg::CMD_W-1:0]          s_cmd,
    input wire [nts_pkg::TIME_W-1:0]         s_time_ns,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [nts_pkg::STATUS_W-1:0]       m_status,
    input wire [nts_pkg::INDEX_W-1:0]        m_entry_index,
    input wire [nts_pkg::TIME_W-1:0]         m_entry_time_ns
);

    // A stalled result transaction holds its payload.
    `NTS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_entry_index) && $stable(m_entry_time_ns))

    // Failed commands carry zero index and time.
    `NTS_ASSERT_SAME(a_fail_zero, aclk, aresetn, m_valid && m_status != nts_pkg::STATUS_OK, m_entry_index == '0 && m_entry_time_ns == '0)

    // The unused status code is never reported.
    `NTS_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_status != nts_pkg::STATUS_BAD)

    // The block works on one command at a time.
    `NTS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind nearest_timestamp_lookup nts_chk u_nts_chk (.*);

`default_nettype wire
